// ===== rtl/tkhc_pkg.sv =====
package tkhc_pkg;

  localparam int OP_W    = 1;
  localparam int SLOT_W  = 5;
  localparam int FIELD_W = 16;
  localparam int KEY_W   = 5;

  localparam logic [OP_W-1:0] OP_WRITE    = 1'b0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 1'b1;

endpackage

// ===== rtl/touch_key_hit_classifier_top.sv =====
// Touch key hit classifier.
// Input channel (in_valid / in_stall) carries one word per item. A write word
// (in_opcode = write) stores a key rectangle at in_key_slot; slots at or
// above NUM_KEYS are dropped. A classify word brings a touch point and
// gives one result word on the output channel (out_valid / out_stall): the
// lowest key whose closed rectangle holds the point with out_touched_inside
// set, else the key with the nearest centre, lowest index on ties.
// The rectangles sit in a table with one write port and one read port, read
// once per cycle; a classify walks all NUM_KEYS entries through a four-stage
// compare pipeline, and the next word can be taken in the cycle in which the
// result appears. A write does not raise in_stall.
// in_stall is high while a classify is in progress. The result sits in an
// output register; while the receiver stalls, further writes are still taken
// and a following classify runs its scan but holds its result until the
// register frees. Reset clears the control and output valid but not the
// rectangle table: a key must be written before any classify reads it.
module touch_key_hit_classifier_top #(
  parameter int NUM_KEYS   = 26,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tkhc_pkg::OP_W-1:0]   in_opcode,
  input  logic [tkhc_pkg::SLOT_W-1:0] in_key_slot,
  input  logic [tkhc_pkg::FIELD_W-1:0] in_left_edge,
  input  logic [tkhc_pkg::FIELD_W-1:0] in_right_edge,
  input  logic [tkhc_pkg::FIELD_W-1:0] in_top_edge,
  input  logic [tkhc_pkg::FIELD_W-1:0] in_bottom_edge,
  input  logic [tkhc_pkg::FIELD_W-1:0] in_point_x,
  input  logic [tkhc_pkg::FIELD_W-1:0] in_point_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tkhc_pkg::KEY_W-1:0]  out_chosen_key,
  output logic                        out_touched_inside
);

  localparam int IDX_W = $clog2(NUM_KEYS);
  localparam int C     = COORD_BITS;
  localparam int ENT_W = 4 * C;
  localparam int A_W   = C + 1;
  localparam int SQ_W  = 2 * A_W;
  localparam int D_W   = SQ_W + 1;
  localparam int SE_W  = IDX_W + tkhc_pkg::SLOT_W;
  localparam int FE_W  = C + tkhc_pkg::FIELD_W;
  localparam int KE_W  = IDX_W + tkhc_pkg::KEY_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t state_r;
  logic   issue_r;
  logic [IDX_W-1:0] cnt_r;
  logic   out_valid_r;
  logic [tkhc_pkg::KEY_W-1:0] out_key_r;
  logic   out_in_r;

  logic [ENT_W-1:0] key_mem [NUM_KEYS];
  logic [ENT_W-1:0] rdata_r;

  logic accept, do_write, start;
  logic [SE_W-1:0] slot_ext;
  logic            slot_ok;
  logic [FE_W-1:0] l_ext, r_ext, t_ext, b_ext, x_ext, y_ext;
  logic [C-1:0]    px_r, py_r;

  logic             rd_v_r, rd_last_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             s1_v_r, s1_last_r, s1_in_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [A_W-1:0]   s1_ax_r, s1_ay_r;
  logic             s2_v_r, s2_last_r, s2_in_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [SQ_W-1:0]  s2_sx_r, s2_sy_r;
  logic [D_W-1:0]   best_d_r;
  logic [IDX_W-1:0] best_idx_r, hit_idx_r;
  logic             hit_r;

  logic [C-1:0]   e_l, e_r, e_t, e_b;
  logic [A_W-1:0] sum_x, sum_y, dbl_x, dbl_y, abs_x, abs_y;
  logic           pt_hit;
  logic [D_W-1:0] d_cur;
  logic [KE_W-1:0] key_ext;
  logic            out_free;

  assign accept   = in_valid && !in_stall;
  assign do_write = accept && (in_opcode == tkhc_pkg::OP_WRITE);
  assign start    = accept && (in_opcode == tkhc_pkg::OP_CLASSIFY);
  assign in_stall = (state_r != ST_IDLE);

  assign slot_ext = {{IDX_W{1'b0}}, in_key_slot};
  assign slot_ok  = slot_ext < SE_W'(NUM_KEYS);
  assign l_ext    = {{C{1'b0}}, in_left_edge};
  assign r_ext    = {{C{1'b0}}, in_right_edge};
  assign t_ext    = {{C{1'b0}}, in_top_edge};
  assign b_ext    = {{C{1'b0}}, in_bottom_edge};
  assign x_ext    = {{C{1'b0}}, in_point_x};
  assign y_ext    = {{C{1'b0}}, in_point_y};

  // rectangle table
  always_ff @(posedge clk) begin
    if (do_write && slot_ok) begin
      key_mem[slot_ext[IDX_W-1:0]] <= {l_ext[C-1:0], r_ext[C-1:0],
                                       t_ext[C-1:0], b_ext[C-1:0]};
    end
    rdata_r <= key_mem[cnt_r];
  end

  assign e_l = rdata_r[4*C-1:3*C];
  assign e_r = rdata_r[3*C-1:2*C];
  assign e_t = rdata_r[2*C-1:C];
  assign e_b = rdata_r[C-1:0];

  always_comb begin
    pt_hit = (e_l <= px_r) && (e_r >= px_r) && (e_t <= py_r) && (e_b >= py_r);
    sum_x  = {1'b0, e_l} + {1'b0, e_r};
    sum_y  = {1'b0, e_t} + {1'b0, e_b};
    dbl_x  = {px_r, 1'b0};
    dbl_y  = {py_r, 1'b0};
    abs_x  = (dbl_x >= sum_x) ? (dbl_x - sum_x) : (sum_x - dbl_x);
    abs_y  = (dbl_y >= sum_y) ? (dbl_y - sum_y) : (sum_y - dbl_y);
    d_cur  = {1'b0, s2_sx_r} + {1'b0, s2_sy_r};
  end

  // compare pipeline: read, distance terms, squares, running best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue_r;
      s1_v_r <= rd_v_r;
      s2_v_r <= s1_v_r;
    end
    if (start) begin
      px_r <= x_ext[C-1:0];
      py_r <= y_ext[C-1:0];
    end
    rd_last_r <= (cnt_r == LAST_IDX);
    rd_idx_r  <= cnt_r;
    s1_last_r <= rd_last_r;
    s1_idx_r  <= rd_idx_r;
    s1_in_r   <= pt_hit;
    s1_ax_r   <= abs_x;
    s1_ay_r   <= abs_y;
    s2_last_r <= s1_last_r;
    s2_idx_r  <= s1_idx_r;
    s2_in_r   <= s1_in_r;
    s2_sx_r   <= {{A_W{1'b0}}, s1_ax_r} * {{A_W{1'b0}}, s1_ax_r};
    s2_sy_r   <= {{A_W{1'b0}}, s1_ay_r} * {{A_W{1'b0}}, s1_ay_r};
    if (start) begin
      hit_r <= 1'b0;
    end else if (s2_v_r) begin
      if (!hit_r && s2_in_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= s2_idx_r;
      end
      if ((s2_idx_r == '0) || (d_cur < best_d_r)) begin
        best_d_r   <= d_cur;
        best_idx_r <= s2_idx_r;
      end
    end
  end

  assign key_ext  = {{tkhc_pkg::KEY_W{1'b0}}, (hit_r ? hit_idx_r : best_idx_r)};
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SCAN;
            issue_r <= 1'b1;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (issue_r) begin
            if (cnt_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end else begin
              cnt_r <= cnt_r + IDX_W'(1);
            end
          end
          if (s2_v_r && s2_last_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_key_r   <= key_ext[tkhc_pkg::KEY_W-1:0];
            out_in_r    <= hit_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_key     = out_key_r;
  assign out_touched_inside = out_in_r;

endmodule

// ===== rtl/tkhc_checker.sv =====
module tkhc_checker #(
  parameter int NUM_KEYS = 26
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [tkhc_pkg::OP_W-1:0]    in_opcode,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tkhc_pkg::KEY_W-1:0]   out_chosen_key,
  input logic                         out_touched_inside
);

  localparam logic [tkhc_pkg::KEY_W:0] KEY_LIM = (tkhc_pkg::KEY_W + 1)'(NUM_KEYS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_chosen_key) && $stable(out_touched_inside))
    else $error("stalled result word changed");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == tkhc_pkg::OP_CLASSIFY) |=> in_stall)
    else $error("classify word did not hold the input");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == tkhc_pkg::OP_WRITE) |=> !in_stall)
    else $error("write word took more than one cycle");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (NUM_KEYS > 32) || ({1'b0, out_chosen_key} < KEY_LIM))
    else $error("chosen key beyond table");

endmodule

bind touch_key_hit_classifier_top tkhc_checker #(.NUM_KEYS(NUM_KEYS)) u_tkhc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_chosen_key     (out_chosen_key),
  .out_touched_inside (out_touched_inside)
);

// ===== verif/tb_touch_key_hit_classifier_top.sv =====
module tb_touch_key_hit_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_KEYS     = 26;
  localparam int COORD_MAX    = (1 << tkhc_pkg::FIELD_W) - 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_ITEMS   = 100;
  localparam int DRAIN_CYCLES = NUM_KEYS + 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [tkhc_pkg::OP_W-1:0]    op;
    logic [tkhc_pkg::SLOT_W-1:0]  slot;
    logic [tkhc_pkg::FIELD_W-1:0] x_lo;
    logic [tkhc_pkg::FIELD_W-1:0] x_hi;
    logic [tkhc_pkg::FIELD_W-1:0] y_lo;
    logic [tkhc_pkg::FIELD_W-1:0] y_hi;
    logic [tkhc_pkg::FIELD_W-1:0] px;
    logic [tkhc_pkg::FIELD_W-1:0] py;
    bit                           typed;
    logic [tkhc_pkg::KEY_W-1:0]   key;
    logic                         touched;
  } touch_row_t;

  typedef struct {
    logic [tkhc_pkg::KEY_W-1:0] key;
    logic                       touched;
  } key_pick_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [tkhc_pkg::OP_W-1:0]    in_opcode = tkhc_pkg::OP_WRITE;
  logic [tkhc_pkg::SLOT_W-1:0]  in_key_slot = '0;
  logic [tkhc_pkg::FIELD_W-1:0] in_left_edge = '0;
  logic [tkhc_pkg::FIELD_W-1:0] in_right_edge = '0;
  logic [tkhc_pkg::FIELD_W-1:0] in_top_edge = '0;
  logic [tkhc_pkg::FIELD_W-1:0] in_bottom_edge = '0;
  logic [tkhc_pkg::FIELD_W-1:0] in_point_x = '0;
  logic [tkhc_pkg::FIELD_W-1:0] in_point_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [tkhc_pkg::KEY_W-1:0]   out_chosen_key;
  logic                         out_touched_inside;

  logic [tkhc_pkg::FIELD_W-1:0] key_x_lo [NUM_KEYS];
  logic [tkhc_pkg::FIELD_W-1:0] key_x_hi [NUM_KEYS];
  logic [tkhc_pkg::FIELD_W-1:0] key_y_lo [NUM_KEYS];
  logic [tkhc_pkg::FIELD_W-1:0] key_y_hi [NUM_KEYS];

  key_pick_t  pending_keys[$];
  touch_row_t script_rows[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         calm_phase = 1'b0;
  bit         quiet_tail = 1'b0;

  touch_key_hit_classifier_top #(
    .NUM_KEYS  (NUM_KEYS),
    .COORD_BITS(tkhc_pkg::FIELD_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_key_slot       (in_key_slot),
    .in_left_edge      (in_left_edge),
    .in_right_edge     (in_right_edge),
    .in_top_edge       (in_top_edge),
    .in_bottom_edge    (in_bottom_edge),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chosen_key    (out_chosen_key),
    .out_touched_inside(out_touched_inside)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [tkhc_pkg::FIELD_W-1:0] clip_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return tkhc_pkg::FIELD_W'(v);
  endfunction

  function automatic touch_row_t write_row(int slot, int xl, int xh, int yl, int yh);
    touch_row_t row;
    row = '{default: '0};
    row.op = tkhc_pkg::OP_WRITE;
    row.slot = tkhc_pkg::SLOT_W'(slot);
    row.x_lo = clip_coord(xl);
    row.x_hi = clip_coord(xh);
    row.y_lo = clip_coord(yl);
    row.y_hi = clip_coord(yh);
    return row;
  endfunction

  function automatic touch_row_t point_row(int x, int y, bit typed = 1'b0, int key = 0,
                                           bit touched = 1'b0);
    touch_row_t row;
    row = '{default: '0};
    row.op = tkhc_pkg::OP_CLASSIFY;
    row.px = clip_coord(x);
    row.py = clip_coord(y);
    row.typed = typed;
    row.key = tkhc_pkg::KEY_W'(key);
    row.touched = touched;
    return row;
  endfunction

  function automatic key_pick_t pick_touched_key(logic [tkhc_pkg::FIELD_W-1:0] x,
                                                 logic [tkhc_pkg::FIELD_W-1:0] y);
    key_pick_t pick;
    longint    dx;
    longint    dy;
    longint    sq_dist;
    longint    best_dist;
    pick.key = '0;
    pick.touched = 1'b0;
    best_dist = 0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!pick.touched && key_x_lo[k] <= x && x <= key_x_hi[k] &&
          key_y_lo[k] <= y && y <= key_y_hi[k]) begin
        pick.key = tkhc_pkg::KEY_W'(k);
        pick.touched = 1'b1;
      end
    end
    if (!pick.touched) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        dx = 2 * longint'(x) - (longint'(key_x_lo[k]) + longint'(key_x_hi[k]));
        dy = 2 * longint'(y) - (longint'(key_y_lo[k]) + longint'(key_y_hi[k]));
        sq_dist = dx * dx + dy * dy;
        if (k == 0 || sq_dist < best_dist) begin
          best_dist = sq_dist;
          pick.key = tkhc_pkg::KEY_W'(k);
        end
      end
    end
    return pick;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_word(input touch_row_t w);
    key_pick_t pick;
    in_valid       <= 1'b1;
    in_opcode      <= w.op;
    in_key_slot    <= w.slot;
    in_left_edge   <= w.x_lo;
    in_right_edge  <= w.x_hi;
    in_top_edge    <= w.y_lo;
    in_bottom_edge <= w.y_hi;
    in_point_x     <= w.px;
    in_point_y     <= w.py;
    do @(posedge clk); while (in_stall);
    if (w.op == tkhc_pkg::OP_WRITE) begin
      if (w.slot < NUM_KEYS) begin
        key_x_lo[w.slot] = w.x_lo;
        key_x_hi[w.slot] = w.x_hi;
        key_y_lo[w.slot] = w.y_lo;
        key_y_hi[w.slot] = w.y_hi;
      end
    end else begin
      if (w.typed) begin
        pick.key = w.key;
        pick.touched = w.touched;
      end else begin
        pick = pick_touched_key(w.px, w.py);
      end
      pending_keys.push_back(pick);
    end
  endtask

  task automatic idle_sender();
    if (!quiet_tail && !calm_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    key_pick_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_keys.size() == 0) begin
        flag_mismatch($sformatf("result word key=%0d inside=%0b with nothing expected",
                                out_chosen_key, out_touched_inside));
      end else begin
        want = pending_keys.pop_front();
        if (out_chosen_key !== want.key)
          flag_mismatch($sformatf("chosen_key %0d, expected %0d", out_chosen_key, want.key));
        if (out_touched_inside !== want.touched)
          flag_mismatch($sformatf("touched_inside %0b, expected %0b",
                                  out_touched_inside, want.touched));
      end
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet_tail && !calm_phase) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    touch_row_t w;
    int         kind;
    int         k;
    int         src;
    int         xl;
    int         xh;
    int         yl;
    int         yh;
    int         x;
    int         y;

    // fill every slot before any classify reads the table
    for (int i = 0; i < NUM_KEYS; i++)
      script_rows.push_back(write_row(i, i * 2000, i * 2000 + 999, 0, 999));
    script_rows.push_back(point_row(0, 0, 1'b1, 0, 1'b1));
    script_rows.push_back(point_row(999, 999, 1'b1, 0, 1'b1));
    script_rows.push_back(point_row(1000, 999));
    script_rows.push_back(point_row(2000, 0, 1'b1, 1, 1'b1));
    script_rows.push_back(point_row(COORD_MAX, COORD_MAX, 1'b1, 25, 1'b0));
    script_rows.push_back(point_row(0, COORD_MAX, 1'b1, 0, 1'b0));
    script_rows.push_back(write_row(31, 0, COORD_MAX, 0, COORD_MAX));
    script_rows.push_back(write_row(NUM_KEYS, 0, COORD_MAX, 0, COORD_MAX));
    script_rows.push_back(point_row(30000, 30000));
    script_rows.push_back(write_row(3, COORD_MAX, 0, COORD_MAX, 0));
    script_rows.push_back(point_row(32768, 32768, 1'b1, 3, 1'b0));
    script_rows.push_back(point_row(6500, 500));
    script_rows.push_back(write_row(10, 0, COORD_MAX, 0, COORD_MAX));
    script_rows.push_back(point_row(COORD_MAX, COORD_MAX, 1'b1, 10, 1'b1));
    script_rows.push_back(point_row(0, 0, 1'b1, 0, 1'b1));
    script_rows.push_back(write_row(10, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    script_rows.push_back(point_row(COORD_MAX, COORD_MAX, 1'b1, 10, 1'b1));
    script_rows.push_back(point_row(COORD_MAX - 1, COORD_MAX));
    script_rows.push_back(write_row(5, 20000, 20010, 60000, 60010));
    script_rows.push_back(write_row(7, 20000, 20010, 60000, 60010));
    script_rows.push_back(point_row(20005, 60020));
    script_rows.push_back(point_row(20010, 60010, 1'b1, 5, 1'b1));
    script_rows.push_back(write_row(0, 0, 0, 0, 0));
    script_rows.push_back(point_row(0, 0, 1'b1, 0, 1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      send_word(script_rows[i]);
      idle_sender();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0)
        calm_phase = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
        quiet_tail = 1'b1;
        calm_phase = 1'b0;
      end
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_keys.size() != 0);
      end

      w.op = ($urandom_range(0, 99) < 35) ? tkhc_pkg::OP_WRITE : tkhc_pkg::OP_CLASSIFY;
      w.slot = tkhc_pkg::SLOT_W'($urandom);
      w.x_lo = tkhc_pkg::FIELD_W'($urandom);
      w.x_hi = tkhc_pkg::FIELD_W'($urandom);
      w.y_lo = tkhc_pkg::FIELD_W'($urandom);
      w.y_hi = tkhc_pkg::FIELD_W'($urandom);
      w.px = tkhc_pkg::FIELD_W'($urandom);
      w.py = tkhc_pkg::FIELD_W'($urandom);
      w.typed = 1'b0;
      w.key = '0;
      w.touched = 1'b0;
      kind = $urandom_range(0, 99);
      k = $urandom_range(0, NUM_KEYS - 1);

      if (w.op == tkhc_pkg::OP_WRITE) begin
        w.slot = ($urandom_range(0, 9) == 0)
                 ? tkhc_pkg::SLOT_W'($urandom_range(NUM_KEYS, 31))
                 : tkhc_pkg::SLOT_W'(k);
        xl = $urandom_range(0, COORD_MAX);
        yl = $urandom_range(0, COORD_MAX);
        if (kind < 50) begin
          w.x_lo = clip_coord(xl);
          w.x_hi = clip_coord(xl + int'($urandom_range(0, 4000)));
          w.y_lo = clip_coord(yl);
          w.y_hi = clip_coord(yl + int'($urandom_range(0, 4000)));
        end else if (kind < 65) begin
          xl = $urandom_range(1, COORD_MAX);
          w.x_lo = clip_coord(xl);
          w.x_hi = clip_coord($urandom_range(0, xl - 1));
          w.y_lo = clip_coord(yl);
          w.y_hi = clip_coord(yl + int'($urandom_range(0, 4000)));
        end else if (kind < 80) begin
          src = $urandom_range(0, NUM_KEYS - 1);
          w.x_lo = key_x_lo[src];
          w.x_hi = key_x_hi[src];
          w.y_lo = key_y_lo[src];
          w.y_hi = key_y_hi[src];
        end else if (kind >= 90) begin
          w.x_lo = $urandom_range(0, 1) ? '1 : '0;
          w.x_hi = $urandom_range(0, 1) ? '1 : '0;
          w.y_lo = $urandom_range(0, 1) ? '1 : '0;
          w.y_hi = $urandom_range(0, 1) ? '1 : '0;
        end
      end else begin
        xl = key_x_lo[k];
        xh = key_x_hi[k];
        yl = key_y_lo[k];
        yh = key_y_hi[k];
        x = w.px;
        y = w.py;
        if (kind < 45 && xl <= xh && yl <= yh) begin
          x = $urandom_range(xl, xh);
          y = $urandom_range(yl, yh);
        end else if (kind < 60) begin
          x = $urandom_range(0, 1) ? xl : xh;
          y = $urandom_range(0, 1) ? yl : yh;
        end else if (kind < 80) begin
          x = (xl + xh) / 2 + int'($urandom_range(0, 600)) - 300;
          y = (yl + yh) / 2 + int'($urandom_range(0, 600)) - 300;
        end else if (kind >= 90) begin
          x = $urandom_range(0, 1) ? COORD_MAX : 0;
          y = $urandom_range(0, 1) ? COORD_MAX : 0;
        end
        w.px = clip_coord(x);
        w.py = clip_coord(y);
      end

      send_word(w);
      idle_sender();
    end

    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
